// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check, active during and after reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpd_pkg
// Shared types and constants of the face-centering PD tracker.
// ----------------------------------------------------------------------------
package fcpd_pkg;

  localparam int FRAC_BITS = 8;
  localparam int GAIN_FRAC = 12;
  localparam int RND_SHIFT = GAIN_FRAC - FRAC_BITS;

  // width of the PD datapath: 11b error x 16b gain plus 12b delta x 16b gain
  localparam int PD_W = 29;

  localparam logic signed [PD_W-1:0] RND_HALF  = PD_W'(1 << (RND_SHIFT - 1));
  localparam logic signed [PD_W-1:0] HORIZ_MIN = PD_W'(-250 * (1 << FRAC_BITS));
  localparam logic signed [PD_W-1:0] HORIZ_MAX = PD_W'(250 * (1 << FRAC_BITS));
  localparam logic signed [PD_W-1:0] VERT_MIN  = PD_W'(175 * (1 << FRAC_BITS));
  localparam logic signed [PD_W-1:0] VERT_MAX  = PD_W'(350 * (1 << FRAC_BITS));

  localparam logic [16:0] VERT_RESET = 17'(200 * (1 << FRAC_BITS));

  localparam logic [9:0] CENTER_X_RESET = 10'd160;
  localparam logic [9:0] CENTER_Y_RESET = 10'd120;
  localparam logic [7:0] DEAD_BAND_RESET = 8'd10;
  localparam logic [7:0] RELEASE_BAND_RESET = 8'd16;

  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_D       = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_DEAD_BAND    = 3'd4,
    REG_RELEASE_BAND = 3'd5
  } fcpd_reg_e;

endpackage

// ===== rtl/face_centering_pd_tracker_top.sv =====
// ----------------------------------------------------------------------------
// face_centering_pd_tracker_top - PD face tracker with center lock
// Registers: input register, then result register; a stalled output holds the word in the input register.
// Throughput: one word per cycle while out_ready_i accepts; the PD step and state update run in one pass.
// Reset: async active low; gains 0, lock off, targets 0 mm / 200 mm.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module face_centering_pd_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // detection in
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         face_count_i,
  input  logic [9:0]         pos_x_i,
  input  logic [9:0]         pos_y_i,
  // targets out
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] target_horiz_o,
  output logic [16:0]        target_vert_o,
  output logic               moved_o,
  output logic               center_locked_o
);

  localparam int W = fcpd_pkg::PD_W;

  // configuration registers
  logic signed [15:0] gain_p_q, gain_d_q;
  logic [9:0]         center_x_q, center_y_q;
  logic [7:0]         dead_band_q, release_band_q;

  fcpd_pkg::fcpd_reg_e reg_idx;
  logic                cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = fcpd_pkg::fcpd_reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q       <= '0;
      gain_d_q       <= '0;
      center_x_q     <= fcpd_pkg::CENTER_X_RESET;
      center_y_q     <= fcpd_pkg::CENTER_Y_RESET;
      dead_band_q    <= fcpd_pkg::DEAD_BAND_RESET;
      release_band_q <= fcpd_pkg::RELEASE_BAND_RESET;
    end else if (cfg_we) begin
      case (reg_idx)
        fcpd_pkg::REG_GAIN_P:       gain_p_q       <= pwdata[15:0];
        fcpd_pkg::REG_GAIN_D:       gain_d_q       <= pwdata[15:0];
        fcpd_pkg::REG_CENTER_X:     center_x_q     <= pwdata[9:0];
        fcpd_pkg::REG_CENTER_Y:     center_y_q     <= pwdata[9:0];
        fcpd_pkg::REG_DEAD_BAND:    dead_band_q    <= pwdata[7:0];
        fcpd_pkg::REG_RELEASE_BAND: release_band_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fcpd_pkg::REG_GAIN_P:       prdata = {16'b0, gain_p_q};
      fcpd_pkg::REG_GAIN_D:       prdata = {16'b0, gain_d_q};
      fcpd_pkg::REG_CENTER_X:     prdata = {22'b0, center_x_q};
      fcpd_pkg::REG_CENTER_Y:     prdata = {22'b0, center_y_q};
      fcpd_pkg::REG_DEAD_BAND:    prdata = {24'b0, dead_band_q};
      fcpd_pkg::REG_RELEASE_BAND: prdata = {24'b0, release_band_q};
      default:                    prdata = '0;
    endcase
  end

  // input register
  logic       in_valid_q;
  logic [7:0] face_count_q;
  logic [9:0] pos_x_q, pos_y_q;
  logic       out_valid_q;
  logic       adv;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      face_count_q <= face_count_i;
      pos_x_q      <= pos_x_i;
      pos_y_q      <= pos_y_i;
    end
  end

  // tracker state
  logic               lock_q;
  logic signed [10:0] prev_x_q, prev_y_q;
  logic signed [16:0] horiz_acc_q;
  logic [16:0]        vert_acc_q;
  logic               moved_q;

  function automatic logic [9:0] abs_err(input logic signed [10:0] e);
    logic signed [10:0] n;
    n = -e;
    return e[10] ? n[9:0] : e[9:0];
  endfunction

  logic signed [10:0] ex_raw, ey_raw, ex, ey;
  logic               rel_ok, dead, detect;
  logic signed [11:0] dx, dy;
  logic signed [W-1:0] mpx, mdx, mpy, mdy, sum_x, sum_y, stp_x, stp_y;
  logic signed [W-1:0] new_h, new_v;
  logic signed [16:0]  horiz_d;
  logic [16:0]         vert_d;

  always_comb begin
    detect = face_count_q != 8'd0;
    ex_raw = $signed({1'b0, center_x_q}) - $signed({1'b0, pos_x_q});
    ey_raw = $signed({1'b0, center_y_q}) - $signed({1'b0, pos_y_q});
    rel_ok = lock_q && (abs_err(ex_raw) <= {2'b0, release_band_q})
                    && (abs_err(ey_raw) <= {2'b0, release_band_q});
    ex     = rel_ok ? '0 : ex_raw;
    ey     = rel_ok ? '0 : ey_raw;
    dead   = (abs_err(ex) <= {2'b0, dead_band_q}) && (abs_err(ey) <= {2'b0, dead_band_q});

    dx    = {ex[10], ex} - {prev_x_q[10], prev_x_q};
    dy    = {ey[10], ey} - {prev_y_q[10], prev_y_q};
    mpx   = W'(ex) * W'(gain_p_q);
    mdx   = W'(dx) * W'(gain_d_q);
    mpy   = W'(ey) * W'(gain_p_q);
    mdy   = W'(dy) * W'(gain_d_q);
    sum_x = mpx + mdx + fcpd_pkg::RND_HALF;
    sum_y = mpy + mdy + fcpd_pkg::RND_HALF;
    stp_x = sum_x >>> fcpd_pkg::RND_SHIFT;
    stp_y = sum_y >>> fcpd_pkg::RND_SHIFT;

    new_h = W'(horiz_acc_q) + stp_x;
    new_v = $signed({{(W-17){1'b0}}, vert_acc_q}) + stp_y;

    if (new_h < fcpd_pkg::HORIZ_MIN) begin
      horiz_d = 17'(fcpd_pkg::HORIZ_MIN);
    end else if (new_h > fcpd_pkg::HORIZ_MAX) begin
      horiz_d = 17'(fcpd_pkg::HORIZ_MAX);
    end else begin
      horiz_d = new_h[16:0];
    end

    if (new_v < fcpd_pkg::VERT_MIN) begin
      vert_d = 17'(fcpd_pkg::VERT_MIN);
    end else if (new_v > fcpd_pkg::VERT_MAX) begin
      vert_d = 17'(fcpd_pkg::VERT_MAX);
    end else begin
      vert_d = new_v[16:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q      <= 1'b0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      horiz_acc_q <= '0;
      vert_acc_q  <= fcpd_pkg::VERT_RESET;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_q <= 1'b1;
        moved_q     <= detect && !dead;
        if (detect) begin
          lock_q <= dead;
          if (dead) begin
            prev_x_q <= '0;
            prev_y_q <= '0;
          end else begin
            prev_x_q    <= ex;
            prev_y_q    <= ey;
            horiz_acc_q <= horiz_d;
            vert_acc_q  <= vert_d;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the state only changes when a word moves into the free result slot,
  // so the state registers are the result fields
  assign out_valid_o     = out_valid_q;
  assign target_horiz_o  = horiz_acc_q;
  assign target_vert_o   = vert_acc_q;
  assign moved_o         = moved_q;
  assign center_locked_o = lock_q;

  `ASSERT_AR(a_horiz_range, clk_i, rst_ni,
             W'(horiz_acc_q) >= fcpd_pkg::HORIZ_MIN && W'(horiz_acc_q) <= fcpd_pkg::HORIZ_MAX,
             "horizontal target out of range")
  `ASSERT_AR(a_vert_range, clk_i, rst_ni,
             vert_acc_q >= 17'(fcpd_pkg::VERT_MIN) && vert_acc_q <= 17'(fcpd_pkg::VERT_MAX),
             "vertical target out of range")
  `ASSERT_AR(a_moved_unlocked, clk_i, rst_ni, out_valid_q && moved_q |-> !lock_q,
             "moved while center lock held")
  `ASSERT_AR(a_state_hold, clk_i, rst_ni,
             !adv |=> $stable(horiz_acc_q) && $stable(vert_acc_q) && $stable(lock_q),
             "tracker state changed without an accepted word")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - face centering PD tracker testbench
// Runs a directed table of detections and register writes, then random
// tracking runs under several register settings. Each output word is checked
// field by field against plan values or a bit-exact tracker model in this bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 300;
  localparam int PIX_TOP     = 1023;
  localparam int H_LO        = -250 * (1 << fcpd_pkg::FRAC_BITS);
  localparam int H_HI        = 250 * (1 << fcpd_pkg::FRAC_BITS);
  localparam int V_LO        = 175 * (1 << fcpd_pkg::FRAC_BITS);
  localparam int V_HI        = 350 * (1 << fcpd_pkg::FRAC_BITS);

  // indexes past the register map, writes must be dropped
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [16:0] horiz;
    logic [16:0]        vert;
    logic               moved;
    logic               locked;
  } target_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] data;
    logic [7:0]  cnt;
    logic [9:0]  px;
    logic [9:0]  py;
    bit          typed;
    target_t     want;
  } plan_row_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [4:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [7:0]         face_count_i = '0;
  logic [9:0]         pos_x_i      = '0;
  logic [9:0]         pos_y_i      = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [16:0] target_horiz_o;
  logic [16:0]        target_vert_o;
  logic               moved_o;
  logic               center_locked_o;

  bit      calm = 1'b0;
  int      mismatches = 0;
  int      cycles = 0;
  target_t pending_targets [$];

  // tracker model state and register copy
  bit lock_st;
  int prev_ex, prev_ey, horiz_st, vert_st;
  int gain_p_c, gain_d_c, ctr_x_c, ctr_y_c, dead_c, rel_c;

  face_centering_pd_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .face_count_i    (face_count_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .target_horiz_o  (target_horiz_o),
    .target_vert_o   (target_vert_o),
    .moved_o         (moved_o),
    .center_locked_o (center_locked_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int iabs(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Q4.12 gain product reduced to Q.8, round half up
  function automatic int pd_term(int e, int prev);
    longint acc;
    acc = longint'(e) * longint'(gain_p_c) + longint'(e - prev) * longint'(gain_d_c);
    return int'((acc + (longint'(1) << (fcpd_pkg::RND_SHIFT - 1))) >>> fcpd_pkg::RND_SHIFT);
  endfunction

  function automatic void tracker_reset();
    lock_st  = 1'b0;
    prev_ex  = 0;
    prev_ey  = 0;
    horiz_st = 0;
    vert_st  = int'(fcpd_pkg::VERT_RESET);
    gain_p_c = 0;
    gain_d_c = 0;
    ctr_x_c  = int'(fcpd_pkg::CENTER_X_RESET);
    ctr_y_c  = int'(fcpd_pkg::CENTER_Y_RESET);
    dead_c   = int'(fcpd_pkg::DEAD_BAND_RESET);
    rel_c    = int'(fcpd_pkg::RELEASE_BAND_RESET);
  endfunction

  function automatic void apply_cfg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      fcpd_pkg::REG_GAIN_P:       gain_p_c = int'($signed(d[15:0]));
      fcpd_pkg::REG_GAIN_D:       gain_d_c = int'($signed(d[15:0]));
      fcpd_pkg::REG_CENTER_X:     ctr_x_c  = int'(d[9:0]);
      fcpd_pkg::REG_CENTER_Y:     ctr_y_c  = int'(d[9:0]);
      fcpd_pkg::REG_DEAD_BAND:    dead_c   = int'(d[7:0]);
      fcpd_pkg::REG_RELEASE_BAND: rel_c    = int'(d[7:0]);
      default: ;
    endcase
  endfunction

  function automatic target_t track_step(logic [7:0] cnt, logic [9:0] px, logic [9:0] py);
    int      ex, ey, oh, ov;
    target_t r;
    r.moved = 1'b0;
    if (cnt != 0) begin
      ex = ctr_x_c - int'(px);
      ey = ctr_y_c - int'(py);
      if (lock_st) begin
        if (iabs(ex) <= rel_c && iabs(ey) <= rel_c) begin
          ex = 0;
          ey = 0;
        end else begin
          lock_st = 1'b0;
        end
      end
      if (iabs(ex) <= dead_c && iabs(ey) <= dead_c) begin
        lock_st = 1'b1;
        prev_ex = 0;
        prev_ey = 0;
      end else begin
        oh       = pd_term(ex, prev_ex);
        ov       = pd_term(ey, prev_ey);
        prev_ex  = ex;
        prev_ey  = ey;
        horiz_st = clip(horiz_st + oh, H_LO, H_HI);
        vert_st  = clip(vert_st + ov, V_LO, V_HI);
        r.moved  = 1'b1;
      end
    end
    r.horiz  = horiz_st[16:0];
    r.vert   = vert_st[16:0];
    r.locked = lock_st;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [31:0] d);
    plan_row_t w;
    w        = '0;
    w.is_cfg = 1'b1;
    w.idx    = idx;
    w.data   = d;
    return w;
  endfunction

  function automatic plan_row_t item_row(logic [7:0] cnt, logic [9:0] px, logic [9:0] py);
    plan_row_t w;
    w     = '0;
    w.cnt = cnt;
    w.px  = px;
    w.py  = py;
    return w;
  endfunction

  function automatic plan_row_t chk_row(logic [7:0] cnt, logic [9:0] px, logic [9:0] py,
                                        int h, int v, bit mv, bit lk);
    plan_row_t w;
    w             = item_row(cnt, px, py);
    w.typed       = 1'b1;
    w.want.horiz  = h[16:0];
    w.want.vert   = v[16:0];
    w.want.moved  = mv;
    w.want.locked = lk;
    return w;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom_range(0, 12288) - 4096);
    endcase
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_targets.size() != 0);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_cfg(idx, d);
  endtask

  task automatic send_word(logic [7:0] cnt, logic [9:0] px, logic [9:0] py,
                           bit typed, target_t want);
    target_t r;
    if (!calm && $urandom_range(99) < 25) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    face_count_i <= cnt;
    pos_x_i      <= px;
    pos_y_i      <= py;
    do @(posedge clk_i); while (!in_ready_o);
    r = track_step(cnt, px, py);
    pending_targets.push_back(typed ? want : r);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk_i) begin : out_check
    target_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_targets.size() == 0) begin
        flag_mismatch("unexpected word", int'(target_horiz_o), 0);
      end else begin
        want = pending_targets.pop_front();
        if (target_horiz_o !== want.horiz)
          flag_mismatch("target_horiz", int'(target_horiz_o), int'($signed(want.horiz)));
        if (target_vert_o !== want.vert)
          flag_mismatch("target_vert", int'(target_vert_o), int'(want.vert));
        if (moved_o !== want.moved)
          flag_mismatch("moved", int'(moved_o), int'(want.moved));
        if (center_locked_o !== want.locked)
          flag_mismatch("center_locked", int'(center_locked_o), int'(want.locked));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t plan [$];
    int          cur_x, cur_y, span, sent, band, r;
    logic [31:0] d;
    logic [7:0]  cnt;

    tracker_reset();
    plan = '{
      chk_row(8'd0,   10'd0,    10'd0,    0, 51200, 1'b0, 1'b0),
      chk_row(8'd1,   10'd160,  10'd120,  0, 51200, 1'b0, 1'b1),
      chk_row(8'd1,   10'd170,  10'd130,  0, 51200, 1'b0, 1'b1),
      chk_row(8'd1,   10'd176,  10'd104,  0, 51200, 1'b0, 1'b1),
      chk_row(8'd1,   10'd177,  10'd120,  0, 51200, 1'b1, 1'b0),
      chk_row(8'd1,   10'd170,  10'd120,  0, 51200, 1'b0, 1'b1),
      chk_row(8'd255, 10'd1023, 10'd1023, 0, 51200, 1'b1, 1'b0),
      cfg_row(fcpd_pkg::REG_GAIN_P, 32'h0000_7FFF),
      cfg_row(fcpd_pkg::REG_GAIN_D, 32'h0000_0000),
      cfg_row(fcpd_pkg::REG_CENTER_X, 32'd1023),
      chk_row(8'd1,   10'd0,    10'd0,    64000, 89600, 1'b1, 1'b0),
      cfg_row(fcpd_pkg::REG_GAIN_P, 32'hFFFF_8000),
      chk_row(8'd1,   10'd0,    10'd0,    -64000, 44800, 1'b1, 1'b0),
      cfg_row(fcpd_pkg::REG_CENTER_X, 32'd0),
      cfg_row(fcpd_pkg::REG_CENTER_Y, 32'd1023),
      cfg_row(fcpd_pkg::REG_DEAD_BAND, 32'd255),
      cfg_row(fcpd_pkg::REG_RELEASE_BAND, 32'd0),
      chk_row(8'd1,   10'd0,    10'd1023, -64000, 44800, 1'b0, 1'b1),
      chk_row(8'd1,   10'd0,    10'd1022, -64000, 44800, 1'b0, 1'b1),
      chk_row(8'd0,   10'd1023, 10'd0,    -64000, 44800, 1'b0, 1'b1),
      cfg_row(REG_SPARE_A, 32'hFFFF_FFFF),
      cfg_row(REG_SPARE_B, 32'h1234_5678),
      cfg_row(fcpd_pkg::REG_GAIN_P, 32'd4096),
      cfg_row(fcpd_pkg::REG_GAIN_D, 32'h0000_7FFF),
      cfg_row(fcpd_pkg::REG_DEAD_BAND, 32'd0),
      cfg_row(fcpd_pkg::REG_RELEASE_BAND, 32'd255),
      cfg_row(fcpd_pkg::REG_CENTER_X, 32'd512),
      cfg_row(fcpd_pkg::REG_CENTER_Y, 32'd512),
      item_row(8'd1,   10'd300,  10'd700),
      item_row(8'd1,   10'd0,    10'd1023),
      item_row(8'd1,   10'd1023, 10'd0),
      item_row(8'd7,   10'd512,  10'd512),
      item_row(8'd1,   10'd700,  10'd300),
      item_row(8'd128, 10'd5,    10'd5),
      // tiny gain: half an LSB either side of zero
      cfg_row(fcpd_pkg::REG_GAIN_P, 32'd1),
      cfg_row(fcpd_pkg::REG_GAIN_D, 32'd0),
      item_row(8'd1,   10'd504,  10'd520),
      item_row(8'd1,   10'd520,  10'd504),
      cfg_row(fcpd_pkg::REG_GAIN_D, 32'hFFFF_8000),
      item_row(8'd1,   10'd600,  10'd400),
      item_row(8'd1,   10'd400,  10'd600),
      item_row(8'd64,  10'd1023, 10'd1023)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        cfg_write(plan[i].idx, plan[i].data);
      else
        send_word(plan[i].cnt, plan[i].px, plan[i].py, plan[i].typed, plan[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 1);
      d = $urandom();
      d[15:0] = pick_gain();
      cfg_write(fcpd_pkg::REG_GAIN_P, d);
      d = $urandom();
      d[15:0] = pick_gain();
      cfg_write(fcpd_pkg::REG_GAIN_D, d);
      cfg_write(fcpd_pkg::REG_CENTER_X, $urandom());
      cfg_write(fcpd_pkg::REG_CENTER_Y, $urandom());
      band = ($urandom_range(5) == 0) ? int'($urandom_range(255)) : int'($urandom_range(24));
      d = $urandom();
      d[7:0] = band[7:0];
      cfg_write(fcpd_pkg::REG_DEAD_BAND, d);
      if ($urandom_range(5) == 0)
        band = int'($urandom_range(255));
      else
        band = clip(band + int'($urandom_range(16)), 0, 255);
      d = $urandom();
      d[7:0] = band[7:0];
      cfg_write(fcpd_pkg::REG_RELEASE_BAND, d);

      cur_x = int'($urandom_range(PIX_TOP));
      cur_y = int'($urandom_range(PIX_TOP));
      sent = 0;
      while (sent < PHASE_WORDS) begin
        r = int'($urandom_range(99));
        if (r < 8) begin
          cnt = 8'd0;
          send_word(cnt, 10'($urandom()), 10'($urandom()), 1'b0, '0);
        end else begin
          if (r < 16) begin
            cur_x = int'($urandom_range(PIX_TOP));
            cur_y = int'($urandom_range(PIX_TOP));
          end else if (r < 50) begin
            span  = rel_c + 3;
            cur_x = ctr_x_c - span + int'($urandom_range(0, 2 * span));
            cur_y = ctr_y_c - span + int'($urandom_range(0, 2 * span));
          end else begin
            cur_x = cur_x + (ctr_x_c - cur_x) / 4 + int'($urandom_range(0, 12)) - 6;
            cur_y = cur_y + (ctr_y_c - cur_y) / 4 + int'($urandom_range(0, 12)) - 6;
          end
          cur_x = clip(cur_x, 0, PIX_TOP);
          cur_y = clip(cur_y, 0, PIX_TOP);
          cnt = 8'($urandom_range(1, 255));
          send_word(cnt, 10'(cur_x), 10'(cur_y), 1'b0, '0);
          sent++;
          if (p == 3 && sent == PHASE_WORDS / 2)
            drain();
        end
      end
    end

    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
